[hdl/mbw_pkg.sv]
// Shared types and constants for the maze backtracker walk block.
`default_nettype none
package mbw_pkg;

    // Action codes
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PASS_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_PASS_HEIGHT = 2'd1;

    localparam int CFG_W       = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int MAP_CALC_W  = 8;
    localparam int DEF_PASS    = 8;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rand_value;
        logic       entry_on_top;
        logic [5:0] entry_index;
        logic [5:0] exit_index;
        logic [6:0] read_row;
        logic [6:0] read_col;
    } in_t;

    typedef struct packed {
        logic [6:0] opened_row;
        logic [6:0] opened_col;
        logic       opened_valid;
        logic       backtracked;
        logic       done_res;
        logic       cell_open;
        logic       error;
    } out_t;

endpackage
`default_nettype wire

[hdl/mbw_row_mem.sv]
// Row memory of pass cells (visited, right-open, down-open) with per-row valid bits.
`default_nettype none
module mbw_row_mem #(
    parameter int ROWS  = 32,
    parameter int WIDTH = 96
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     clear,
    input  wire logic                     we,
    input  wire logic [$clog2(ROWS)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(ROWS)-1:0]  raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [ROWS];
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic [ROWS-1:0]  valid_reg;
    logic [ROWS-1:0]  valid_next;

    // Write and read the row storage
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    // Drop all rows on clear, mark written rows
    always_comb
    begin
        valid_next = clear ? '0 : valid_reg;
        if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    // Unwritten rows read as all zero
    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

[hdl/mbw_stack_mem.sv]
// Return stack memory of pass cell positions.
`default_nettype none
module mbw_stack_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write the pushed item, read the top entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule
`default_nettype wire

[hdl/maze_backtracker_walk_core.sv]
// Timing: start, error and plain reads give their result in the cycle after the item is taken;
// inner wall reads use ST_RD; steps use ST_W1 to ST_W3; a down move adds ST_WDN, a pop ST_POP.
// A step reads the current, upper and lower rows through the row memory's one read port in
// turn, then on a move writes back one row (two for a down move); that port sets the step time.
// Throughput: one item at a time, the next may start in the cycle its result is shown.
// Reset: map all wall, walk finished, size 8 x 8; no clearing pass is needed.
`default_nettype none
module maze_backtracker_walk_core #(
    parameter int MAX_PASS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire mbw_pkg::in_t                   item,
    output logic                                res_strobe,
    output mbw_pkg::out_t                       res,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mbw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mbw_pkg::CFG_W-1:0]      cfg_data
);
    import mbw_pkg::*;

    localparam int IDX_W  = $clog2(MAX_PASS);
    localparam int DIM_W  = $clog2(MAX_PASS + 1);
    localparam int WORD_W = 3 * MAX_PASS;
    localparam int SEL_W  = $clog2(WORD_W);
    localparam int DEPTH  = MAX_PASS * MAX_PASS;
    localparam int SA_W   = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CW     = MAP_CALC_W;
    localparam int RESET_DIM = (DEF_PASS < MAX_PASS) ? DEF_PASS : MAX_PASS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_W1   = 3'd1;
    localparam logic [2:0] ST_W2   = 3'd2;
    localparam logic [2:0] ST_W3   = 3'd3;
    localparam logic [2:0] ST_WDN  = 3'd4;
    localparam logic [2:0] ST_POP  = 3'd5;
    localparam logic [2:0] ST_RD   = 3'd6;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Clamp a value to 1..hi
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [6:0] v, input logic [6:0] hi);
        logic [6:0] r;
        begin
            if (v == 7'd0)
                r = 7'd1;
            else if (v > hi)
                r = hi;
            else
                r = v;
            return r[DIM_W-1:0];
        end
    endfunction

    // Byte modulo three through base-four digit sum
    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s;
        logic [1:0] m;
        begin
            s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
            case (s)
                4'd0, 4'd3, 4'd6, 4'd9, 4'd12: m = 2'd0;
                4'd1, 4'd4, 4'd7, 4'd10:       m = 2'd1;
                default:                       m = 2'd2;
            endcase
            return m;
        end
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [CFG_W-1:0]  pw_reg, ph_reg;
    logic [DIM_W-1:0]  walk_w_reg, walk_w_next, walk_h_reg, walk_h_next;
    logic              ent_top_reg, ent_top_next;
    logic [DIM_W-1:0]  ent_pos_reg, ent_pos_next, ext_pos_reg, ext_pos_next;
    logic              built_reg, built_next;
    logic              finished_reg, finished_next;
    logic [IDX_W-1:0]  cur_r_reg, cur_r_next, cur_c_reg, cur_c_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] cur_word_reg, cur_word_next, up_word_reg, up_word_next;
    logic [WORD_W-1:0] dn_word_reg, dn_word_next;
    logic [SEL_W-1:0]  rd_sel_reg, rd_sel_next;
    out_t              res_reg, res_next;
    logic              strobe_reg, strobe_next;
    logic [7:0]        item_rand_reg;

    logic              mem_clear, mem_we;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;
    logic              stk_we;
    logic [SA_W-1:0]   stk_waddr, stk_raddr;
    logic [2*IDX_W-1:0] stk_wdata, stk_rdata;

    logic [DIM_W-1:0]  new_w, new_h, new_lim;
    logic [CW-1:0]     rr8, rc8, h2, w2, e2m1, x2m1;
    logic              rd_oob, rd_border, rd_mem, rd_imm;
    logic [IDX_W-1:0]  rd_row;
    logic [SEL_W-1:0]  rd_sel;

    logic [MAX_PASS-1:0] vis_c, vis_u, vis_d;
    logic [IDX_W-1:0]  c_m1, c_p1, r_m1, r_p1;
    logic [3:0]        cand;
    logic [2:0]        n_cand;
    logic [1:0]        pick, dir;
    logic [2:0]        seen;
    logic [CW-1:0]     base_r, base_c, o_row8, o_col8;
    logic [WORD_W-1:0] vis_mask_l, vis_mask_c, vis_mask_r;
    logic [WORD_W-1:0] right_mask_l, right_mask_c, down_mask_c;
    logic [CNT_W-1:0]  cnt_m1;

    mbw_row_mem #(
        .ROWS  (MAX_PASS),
        .WIDTH (WORD_W)
    ) u_row_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (mem_clear),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mbw_stack_mem #(
        .DEPTH (DEPTH),
        .WIDTH (2 * IDX_W)
    ) u_stack_mem (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign busy       = (state_reg != ST_IDLE);
    assign res_strobe = strobe_reg;
    assign res        = res_reg;
    assign cfg_ready  = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg <= CFG_W'(DEF_PASS);
            ph_reg <= CFG_W'(DEF_PASS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_PASS_WIDTH)
                pw_reg <= cfg_data;
            else if (cfg_index == CFG_PASS_HEIGHT)
                ph_reg <= cfg_data;
        end
    end

    // Clamp walk size and entrance positions for a start item
    always_comb
    begin
        new_w   = clamp_dim({1'b0, pw_reg}, 7'(MAX_PASS));
        new_h   = clamp_dim({1'b0, ph_reg}, 7'(MAX_PASS));
        new_lim = item.entry_on_top ? new_w : new_h;
    end

    // Decode a map read against the latched walk
    always_comb
    begin
        rr8    = CW'(item.read_row);
        rc8    = CW'(item.read_col);
        h2     = CW'(walk_h_reg) << 1;
        w2     = CW'(walk_w_reg) << 1;
        e2m1   = (CW'(ent_pos_reg) << 1) - CW'(1);
        x2m1   = (CW'(ext_pos_reg) << 1) - CW'(1);
        rd_oob = (rr8 > h2) || (rc8 > w2);
        rd_border = built_reg && (
                    (rr8 == '0 && ent_top_reg && rc8 == e2m1) ||
                    (rr8 == h2 && ent_top_reg && rc8 == x2m1) ||
                    (rc8 == '0 && !ent_top_reg && rr8 == e2m1) ||
                    (rc8 == w2 && !ent_top_reg && rr8 == x2m1));
        rd_mem = 1'b0;
        rd_imm = 1'b0;
        rd_row = '0;
        rd_sel = '0;
        if (rr8 == '0 || rr8 == h2 || rc8 == '0 || rc8 == w2)
        begin
            rd_imm = rd_border;
        end
        else if (rr8[0] && rc8[0])
        begin
            rd_imm = built_reg;
        end
        else if (rr8[0])
        begin
            rd_mem = 1'b1;
            rd_row = IDX_W'(rr8 >> 1);
            rd_sel = SEL_W'(MAX_PASS) + SEL_W'((rc8 >> 1) - CW'(1));
        end
        else if (rc8[0])
        begin
            rd_mem = 1'b1;
            rd_row = IDX_W'((rr8 >> 1) - CW'(1));
            rd_sel = SEL_W'(2 * MAX_PASS) + SEL_W'(rc8 >> 1);
        end
    end

    // Find unvisited neighbors and pick one
    always_comb
    begin
        vis_c = cur_word_reg[MAX_PASS-1:0];
        vis_u = up_word_reg[MAX_PASS-1:0];
        vis_d = mem_rdata[MAX_PASS-1:0];
        c_m1  = cur_c_reg - IDX_W'(1);
        c_p1  = cur_c_reg + IDX_W'(1);
        r_m1  = cur_r_reg - IDX_W'(1);
        r_p1  = cur_r_reg + IDX_W'(1);
        cand[0] = (cur_c_reg != '0) && !vis_c[c_m1];
        cand[1] = (cur_r_reg != '0) && !vis_u[cur_c_reg];
        cand[2] = ((DIM_W'(cur_c_reg) + DIM_W'(1)) < walk_w_reg) && !vis_c[c_p1];
        cand[3] = ((DIM_W'(cur_r_reg) + DIM_W'(1)) < walk_h_reg) && !vis_d[cur_c_reg];
        n_cand  = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
        case (n_cand)
            3'd2:    pick = {1'b0, item_rand_reg[0]};
            3'd3:    pick = mod3(item_rand_reg);
            3'd4:    pick = item_rand_reg[1:0];
            default: pick = 2'd0;
        endcase
        dir  = DIR_LEFT;
        seen = 3'd0;
        for (int k = 0; k < 4; k++)
        begin
            if (cand[k])
            begin
                if (seen == 3'(pick))
                    dir = 2'(k);
                seen = seen + 3'd1;
            end
        end
        base_r = (CW'(cur_r_reg) << 1) + CW'(1);
        base_c = (CW'(cur_c_reg) << 1) + CW'(1);
        o_row8 = base_r;
        o_col8 = base_c;
        case (dir)
            DIR_LEFT:  o_col8 = base_c - CW'(1);
            DIR_UP:    o_row8 = base_r - CW'(1);
            DIR_RIGHT: o_col8 = base_c + CW'(1);
            DIR_DOWN:  o_row8 = base_r + CW'(1);
            default:   o_row8 = base_r;
        endcase
        vis_mask_l   = WORD_W'(1) << c_m1;
        vis_mask_c   = WORD_W'(1) << cur_c_reg;
        vis_mask_r   = WORD_W'(1) << c_p1;
        right_mask_l = WORD_W'(1) << (SEL_W'(MAX_PASS) + SEL_W'(c_m1));
        right_mask_c = WORD_W'(1) << (SEL_W'(MAX_PASS) + SEL_W'(cur_c_reg));
        down_mask_c  = WORD_W'(1) << (SEL_W'(2 * MAX_PASS) + SEL_W'(cur_c_reg));
        cnt_m1       = cnt_reg - CNT_W'(1);
    end

    // Random byte of the step in progress
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            item_rand_reg <= item.rand_value;
    end

    // Sequence start, step and read items
    always_comb
    begin
        state_next    = state_reg;
        walk_w_next   = walk_w_reg;
        walk_h_next   = walk_h_reg;
        ent_top_next  = ent_top_reg;
        ent_pos_next  = ent_pos_reg;
        ext_pos_next  = ext_pos_reg;
        built_next    = built_reg;
        finished_next = finished_reg;
        cur_r_next    = cur_r_reg;
        cur_c_next    = cur_c_reg;
        cnt_next      = cnt_reg;
        cur_word_next = cur_word_reg;
        up_word_next  = up_word_reg;
        dn_word_next  = dn_word_reg;
        rd_sel_next   = rd_sel_reg;
        res_next      = res_reg;
        strobe_next   = 1'b0;
        mem_clear     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = cur_r_reg;
        mem_wdata     = cur_word_reg;
        mem_raddr     = cur_r_reg;
        stk_we        = 1'b0;
        stk_waddr     = cnt_reg[SA_W-1:0];
        stk_wdata     = {cur_r_reg, cur_c_reg};
        stk_raddr     = cnt_m1[SA_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    res_next = '0;
                    case (item.action)
                        ACT_START:
                        begin
                            walk_w_next   = new_w;
                            walk_h_next   = new_h;
                            ent_top_next  = item.entry_on_top;
                            ent_pos_next  = clamp_dim({1'b0, item.entry_index}, 7'(new_lim));
                            ext_pos_next  = clamp_dim({1'b0, item.exit_index}, 7'(new_lim));
                            built_next    = 1'b1;
                            finished_next = 1'b0;
                            cur_r_next    = '0;
                            cur_c_next    = '0;
                            cnt_next      = '0;
                            mem_clear     = 1'b1;
                            mem_we        = 1'b1;
                            mem_waddr     = '0;
                            mem_wdata     = WORD_W'(1);
                            strobe_next   = 1'b1;
                        end
                        ACT_STEP:
                        begin
                            if (finished_reg)
                            begin
                                res_next.error    = 1'b1;
                                res_next.done_res = 1'b1;
                                strobe_next       = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_W1;
                            end
                        end
                        ACT_READ:
                        begin
                            res_next.done_res = finished_reg;
                            if (rd_oob)
                            begin
                                res_next.error = 1'b1;
                                strobe_next    = 1'b1;
                            end
                            else if (rd_mem)
                            begin
                                mem_raddr   = rd_row;
                                rd_sel_next = rd_sel;
                                state_next  = ST_RD;
                            end
                            else
                            begin
                                res_next.cell_open = rd_imm;
                                strobe_next        = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_next.done_res = finished_reg;
                            strobe_next       = 1'b1;
                        end
                    endcase
                end
            end

            ST_W1:
            begin
                cur_word_next = mem_rdata;
                mem_raddr     = r_m1;
                state_next    = ST_W2;
            end

            ST_W2:
            begin
                up_word_next = mem_rdata;
                mem_raddr    = r_p1;
                state_next   = ST_W3;
            end

            ST_W3:
            begin
                res_next = '0;
                if (n_cand != 3'd0)
                begin
                    res_next.opened_row   = o_row8[6:0];
                    res_next.opened_col   = o_col8[6:0];
                    res_next.opened_valid = 1'b1;
                    if (n_cand > 3'd1 && cnt_reg < CNT_W'(DEPTH))
                    begin
                        stk_we   = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    mem_we     = 1'b1;
                    state_next = ST_IDLE;
                    case (dir)
                        DIR_LEFT:
                        begin
                            mem_wdata  = cur_word_reg | vis_mask_l | right_mask_l;
                            cur_c_next = c_m1;
                        end
                        DIR_UP:
                        begin
                            mem_waddr  = r_m1;
                            mem_wdata  = up_word_reg | vis_mask_c | down_mask_c;
                            cur_r_next = r_m1;
                        end
                        DIR_RIGHT:
                        begin
                            mem_wdata  = cur_word_reg | vis_mask_r | right_mask_c;
                            cur_c_next = c_p1;
                        end
                        default:
                        begin
                            mem_wdata    = cur_word_reg | down_mask_c;
                            dn_word_next = mem_rdata | vis_mask_c;
                            cur_r_next   = r_p1;
                            state_next   = ST_WDN;
                        end
                    endcase
                    strobe_next = (dir != DIR_DOWN);
                end
                else if (cnt_reg != '0)
                begin
                    res_next.backtracked = 1'b1;
                    cnt_next             = cnt_m1;
                    state_next           = ST_POP;
                end
                else
                begin
                    finished_next     = 1'b1;
                    res_next.done_res = 1'b1;
                    strobe_next       = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            ST_WDN:
            begin
                mem_we      = 1'b1;
                mem_wdata   = dn_word_reg;
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end

            ST_POP:
            begin
                cur_r_next  = stk_rdata[2*IDX_W-1:IDX_W];
                cur_c_next  = stk_rdata[IDX_W-1:0];
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end

            ST_RD:
            begin
                res_next.cell_open = mem_rdata[rd_sel_reg];
                strobe_next        = 1'b1;
                state_next         = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            walk_w_reg   <= DIM_W'(RESET_DIM);
            walk_h_reg   <= DIM_W'(RESET_DIM);
            ent_top_reg  <= 1'b0;
            ent_pos_reg  <= '0;
            ext_pos_reg  <= '0;
            built_reg    <= 1'b0;
            finished_reg <= 1'b1;
            cur_r_reg    <= '0;
            cur_c_reg    <= '0;
            cnt_reg      <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            walk_w_reg   <= walk_w_next;
            walk_h_reg   <= walk_h_next;
            ent_top_reg  <= ent_top_next;
            ent_pos_reg  <= ent_pos_next;
            ext_pos_reg  <= ext_pos_next;
            built_reg    <= built_next;
            finished_reg <= finished_next;
            cur_r_reg    <= cur_r_next;
            cur_c_reg    <= cur_c_next;
            cnt_reg      <= cnt_next;
            strobe_reg   <= strobe_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        cur_word_reg <= cur_word_next;
        up_word_reg  <= up_word_next;
        dn_word_reg  <= dn_word_next;
        rd_sel_reg   <= rd_sel_next;
        res_reg      <= res_next;
    end

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the maze backtracker walk core with a built-in walk predictor.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mbw_pkg::*;

    localparam int MAXP = 32;
    localparam int DIM  = 2 * MAXP + 1;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  item;
    logic res_strobe;
    out_t res;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    maze_backtracker_walk_core #(.MAX_PASS(MAXP)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .res_strobe(res_strobe), .res(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Walk predictor state
    logic        wall_open [0:DIM-1][0:DIM-1];
    logic        seen [0:MAXP-1][0:MAXP-1];
    logic [4:0]  trail_row [0:MAXP*MAXP-1];
    logic [4:0]  trail_col [0:MAXP*MAXP-1];
    int          trail_depth;
    int          cur_row;
    int          cur_col;
    logic        walk_done;
    int          walk_w;
    int          walk_h;
    logic [5:0]  reg_width;
    logic [5:0]  reg_height;

    in_t  item_queue [$];
    out_t expected_results [$];
    int   idle_pct;
    int   errs;
    int   quiet_cycles;

    function automatic int clamp_pass(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Work out the result of one accepted item and advance the walk state
    task automatic apply_item(input in_t it);
        out_t o;
        int dr [4];
        int dc [4];
        int cand [4];
        int cnt;
        int d;
        int nr;
        int nc;
        int e;
        int x;
        dr = '{0, -1, 0, 1};
        dc = '{-1, 0, 1, 0};
        o = '0;
        case (it.action)
            ACT_START:
            begin
                walk_w = clamp_pass(reg_width, MAXP);
                walk_h = clamp_pass(reg_height, MAXP);
                for (int r = 0; r < DIM; r++)
                    for (int c = 0; c < DIM; c++)
                        wall_open[r][c] = 1'b0;
                for (int r = 0; r < MAXP; r++)
                    for (int c = 0; c < MAXP; c++)
                        seen[r][c] = 1'b0;
                for (int r = 0; r < walk_h; r++)
                    for (int c = 0; c < walk_w; c++)
                        wall_open[2*r+1][2*c+1] = 1'b1;
                if (it.entry_on_top)
                begin
                    e = clamp_pass(it.entry_index, walk_w);
                    x = clamp_pass(it.exit_index, walk_w);
                    wall_open[0][2*e-1] = 1'b1;
                    wall_open[2*walk_h][2*x-1] = 1'b1;
                end
                else
                begin
                    e = clamp_pass(it.entry_index, walk_h);
                    x = clamp_pass(it.exit_index, walk_h);
                    wall_open[2*e-1][0] = 1'b1;
                    wall_open[2*x-1][2*walk_w] = 1'b1;
                end
                trail_depth = 0;
                cur_row = 0;
                cur_col = 0;
                seen[0][0] = 1'b1;
                walk_done = 1'b0;
            end
            ACT_STEP:
            begin
                if (walk_done)
                    o.error = 1'b1;
                else
                begin
                    cnt = 0;
                    seen[cur_row][cur_col] = 1'b1;
                    for (int k = 0; k < 4; k++)
                    begin
                        nr = cur_row + dr[k];
                        nc = cur_col + dc[k];
                        if (nr >= 0 && nc >= 0 && nr < walk_h && nc < walk_w && !seen[nr][nc])
                        begin
                            cand[cnt] = k;
                            cnt++;
                        end
                    end
                    if (cnt > 0)
                    begin
                        d = cand[it.rand_value % cnt];
                        nr = cur_row + dr[d];
                        nc = cur_col + dc[d];
                        o.opened_row = 7'(2*cur_row + 1 + dr[d]);
                        o.opened_col = 7'(2*cur_col + 1 + dc[d]);
                        o.opened_valid = 1'b1;
                        wall_open[o.opened_row][o.opened_col] = 1'b1;
                        seen[nr][nc] = 1'b1;
                        if (cnt > 1 && trail_depth < MAXP*MAXP)
                        begin
                            trail_row[trail_depth] = 5'(cur_row);
                            trail_col[trail_depth] = 5'(cur_col);
                            trail_depth++;
                        end
                        cur_row = nr;
                        cur_col = nc;
                    end
                    else if (trail_depth > 0)
                    begin
                        trail_depth--;
                        cur_row = trail_row[trail_depth];
                        cur_col = trail_col[trail_depth];
                        o.backtracked = 1'b1;
                    end
                    else
                        walk_done = 1'b1;
                end
            end
            ACT_READ:
            begin
                if (it.read_row >= 2*walk_h + 1 || it.read_col >= 2*walk_w + 1)
                    o.error = 1'b1;
                else
                    o.cell_open = wall_open[it.read_row][it.read_col];
            end
            default: ;
        endcase
        o.done_res = walk_done;
        expected_results.push_back(o);
    endtask

    // Feed items from the pending queue, idling at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
            for (int r = 0; r < DIM; r++)
                for (int c = 0; c < DIM; c++)
                    wall_open[r][c] = 1'b0;
            trail_depth = 0;
            cur_row = 0;
            cur_col = 0;
            walk_done = 1'b1;
            walk_w = DEF_PASS;
            walk_h = DEF_PASS;
        end
        else if (!start || !busy)
        begin
            if (start)
                apply_item(item);
            if (item_queue.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                start <= 1'b1;
                item <= item_queue.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    task automatic field_check(input string name, input int e, input int a);
        if (e != a)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
            errs++;
        end
    endtask

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_strobe)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, res);
                errs++;
            end
            else
            begin
                out_t exp_res;
                exp_res = expected_results.pop_front();
                field_check("opened_row", exp_res.opened_row, res.opened_row);
                field_check("opened_col", exp_res.opened_col, res.opened_col);
                field_check("opened_valid", exp_res.opened_valid, res.opened_valid);
                field_check("backtracked", exp_res.backtracked, res.backtracked);
                field_check("done_res", exp_res.done_res, res.done_res);
                field_check("cell_open", exp_res.cell_open, res.cell_open);
                field_check("error", exp_res.error, res.error);
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        if ((start && !busy) || res_strobe || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic in_t make_item(input logic [1:0] act, input int rv, input int top,
                                      input int ent, input int ext, input int rr, input int rc);
        in_t it;
        it.action = act;
        it.rand_value = 8'(rv);
        it.entry_on_top = 1'(top);
        it.entry_index = 6'(ent);
        it.exit_index = 6'(ext);
        it.read_row = 7'(rr);
        it.read_col = 7'(rc);
        return it;
    endfunction

    function automatic in_t noise_item(input logic [1:0] act);
        return make_item(act, $urandom_range(255), $urandom_range(1), $urandom_range(63),
                         $urandom_range(63), $urandom_range(127), $urandom_range(127));
    endfunction

    // Queue one start plus a random walk sized for the current setting
    task automatic queue_walk(input int ww, input int hh, input int budget);
        int n;
        int pick;
        in_t it;
        it = noise_item(ACT_START);
        if ($urandom_range(3) != 0)
        begin
            it.entry_index = 6'($urandom_range(1, 32));
            it.exit_index = 6'($urandom_range(1, 32));
        end
        item_queue.push_back(it);
        n = 0;
        while (n < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                item_queue.push_back(noise_item(ACT_STEP));
            else if (pick < 92)
            begin
                it = noise_item(ACT_READ);
                it.read_row = 7'($urandom_range(2*hh));
                it.read_col = 7'($urandom_range(2*ww));
                item_queue.push_back(it);
            end
            else if (pick < 97)
                item_queue.push_back(noise_item(ACT_READ));
            else
                item_queue.push_back(noise_item(2'd3));
            n++;
        end
    endtask

    task automatic wait_idle();
        while (item_queue.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_PASS_WIDTH)
            reg_width = val;
        else
            reg_height = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    int set_w [7] = '{1, 32, 0, 3, 5, 63, 2};
    int set_h [7] = '{1, 32, 63, 2, 4, 0, 6};
    int set_idle [7] = '{0, 53, 24, 0, 53, 24, 0};

    initial
    begin
        int ww;
        int hh;
        int spent;
        int chunk;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        reg_width = 6'(DEF_PASS);
        reg_height = 6'(DEF_PASS);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: step before any start, unknown action, reads at the map bounds
        item_queue.push_back(make_item(ACT_STEP, 0, 0, 0, 0, 0, 0));
        item_queue.push_back(make_item(2'd3, 255, 1, 63, 63, 127, 127));
        item_queue.push_back(make_item(ACT_READ, 0, 0, 0, 0, 0, 0));
        item_queue.push_back(make_item(ACT_READ, 0, 0, 0, 0, 16, 16));
        item_queue.push_back(make_item(ACT_READ, 0, 0, 0, 0, 17, 0));
        item_queue.push_back(make_item(ACT_READ, 0, 0, 0, 0, 127, 127));
        // Clamped entrance and exit on top and bottom
        item_queue.push_back(make_item(ACT_START, 0, 1, 0, 63, 0, 0));
        item_queue.push_back(make_item(ACT_READ, 0, 0, 0, 0, 0, 1));
        item_queue.push_back(make_item(ACT_READ, 0, 0, 0, 0, 16, 15));
        item_queue.push_back(make_item(ACT_STEP, 0, 0, 0, 0, 0, 0));
        item_queue.push_back(make_item(ACT_STEP, 255, 0, 0, 0, 0, 0));
        item_queue.push_back(make_item(ACT_STEP, 1, 0, 0, 0, 0, 0));
        item_queue.push_back(make_item(ACT_READ, 0, 0, 0, 0, 1, 2));
        // Left and right openings, clamped
        item_queue.push_back(make_item(ACT_START, 7, 0, 63, 0, 0, 0));
        item_queue.push_back(make_item(ACT_READ, 0, 0, 0, 0, 15, 0));
        item_queue.push_back(make_item(ACT_READ, 0, 0, 0, 0, 1, 16));
        item_queue.push_back(make_item(ACT_READ, 0, 0, 0, 0, 0, 17));
        for (int i = 0; i < 6; i++)
            item_queue.push_back(make_item(ACT_STEP, 3 * i, 0, 0, 0, 0, 0));
        wait_idle();

        // Random walks over several sizes, extremes and out-of-range values included
        for (int p = 0; p < 7; p++)
        begin
            write_reg(CFG_PASS_WIDTH, 6'(set_w[p]));
            write_reg(CFG_PASS_HEIGHT, 6'(set_h[p]));
            @(posedge clk);
            ww = clamp_pass(set_w[p], MAXP);
            hh = clamp_pass(set_h[p], MAXP);
            idle_pct = set_idle[p];
            spent = 0;
            while (spent < 160)
            begin
                chunk = 3 * ww * hh + 4;
                if (chunk > 160)
                    chunk = 160;
                queue_walk(ww, hh, chunk);
                spent += chunk + 1;
            end
            wait_idle();
        end

        if (errs == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
hdl/mbw_pkg.sv
hdl/mbw_row_mem.sv
hdl/mbw_stack_mem.sv
hdl/maze_backtracker_walk_core.sv
tb/tb.sv
